// File: rtl/tpq_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the two level priority task queue
// no dependencies; used by the top, the lane, the checker and the bench
package tpq_pkg;

    // fixed field widths of the request and result ports
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;
    localparam int SIZE_W   = 5;
    localparam int CAP_W    = 5;
    localparam int FIELD_W  = 32;
    localparam int CFG_IDX_W = 1;

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_PUSH_HIGH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_LOW  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP       = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SHUTDOWN  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SHUTDOWN = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CAP  = 1'b1;

    // lane lane controls from the scheduler
    typedef struct packed {
        logic push;
        logic pop;
    } t_lane_ctl;

    // lane status back to the scheduler
    typedef struct packed {
        logic full;
        logic empty;
    } t_lane_stat;

endpackage

// File: rtl/two_level_priority_task_queue.sv
`timescale 1ns / 1ps
// two level priority task queue: result strobe in the cycle after a request;
// one request per cycle while not busy; a pop reads the head entry from lane ram
// and the ram's registered read port gives the task in the result cycle
// o_busy is high for the first cycle after reset only; results cannot be stalled
// synchronous active low reset clears fills, heads, totals, shutdown flag,
// capacities back to sixteen; entry contents are not cleared
module two_level_priority_task_queue #(
    parameter int HIGH_DEPTH = 16,
    parameter int LOW_DEPTH  = 16,
    parameter int TASK_BITS  = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [tpq_pkg::ACTION_W-1:0]  i_action,
    input  logic [tpq_pkg::FIELD_W-1:0]   i_task_word,
    input  logic                          i_cfg_we,
    input  logic [tpq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tpq_pkg::CAP_W-1:0]     i_cfg_data,
    output logic                          o_valid,
    output logic [tpq_pkg::STATUS_W-1:0]  o_status,
    output logic [tpq_pkg::FIELD_W-1:0]   o_popped_task,
    output logic                          o_popped_lane,
    output logic [tpq_pkg::SIZE_W-1:0]    o_high_size,
    output logic [tpq_pkg::SIZE_W-1:0]    o_low_size,
    output logic [tpq_pkg::FIELD_W-1:0]   o_high_rejected,
    output logic [tpq_pkg::FIELD_W-1:0]   o_low_rejected,
    output logic [tpq_pkg::FIELD_W-1:0]   o_high_enqueued,
    output logic [tpq_pkg::FIELD_W-1:0]   o_low_enqueued
);
    import tpq_pkg::*;

    localparam int SW  = (TASK_BITS < FIELD_W) ? TASK_BITS : FIELD_W;
    localparam int HCW = $clog2(HIGH_DEPTH + 1);
    localparam int LCW = $clog2(LOW_DEPTH + 1);

    logic                r_live;
    logic                r_stopped, n_stopped;
    logic [CAP_W-1:0]    r_high_cap;
    logic [CAP_W-1:0]    r_low_cap;
    logic                r_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_popped, n_popped;
    logic                r_lane, n_lane;

    logic                  accept;
    t_lane_ctl             high_ctl, low_ctl;
    t_lane_stat            high_stat, low_stat;
    logic [HCW-1:0]        high_count;
    logic [LCW-1:0]        low_count;
    logic [SW-1:0]         high_rdata, low_rdata;
    logic [COUNT_BITS-1:0] high_rej, low_rej, high_enq, low_enq;
    logic [SW-1:0]         word;

    assign accept = i_start && r_live;
    assign word   = i_task_word[SW-1:0];

    // request decode: lane controls and result status
    always_comb begin
        high_ctl  = '0;
        low_ctl   = '0;
        n_stopped = r_stopped;
        n_status  = ST_EMPTY;
        n_popped  = 1'b0;
        n_lane    = 1'b0;
        case (i_action)
            ACT_PUSH_HIGH: begin
                high_ctl.push = accept;
                n_status = high_stat.full ? ST_REJECTED : ST_ACCEPTED;
            end
            ACT_PUSH_LOW: begin
                low_ctl.push = accept;
                n_status = low_stat.full ? ST_REJECTED : ST_ACCEPTED;
            end
            ACT_POP: begin
                if (r_stopped) begin
                    n_status = ST_SHUTDOWN;
                end else if (!high_stat.empty) begin
                    high_ctl.pop = accept;
                    n_status = ST_POPPED;
                    n_popped = 1'b1;
                end else if (!low_stat.empty) begin
                    low_ctl.pop = accept;
                    n_status = ST_POPPED;
                    n_popped = 1'b1;
                    n_lane   = 1'b1;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            ACT_SHUTDOWN: begin
                n_stopped = r_stopped || accept;
                n_status  = ST_SHUTDOWN;
            end
            default: begin
                n_status = ST_EMPTY;
            end
        endcase
    end

    // control state and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= 1'b0;
            r_stopped  <= 1'b0;
            r_valid    <= 1'b0;
            r_popped   <= 1'b0;
            r_high_cap <= CAP_RESET;
            r_low_cap  <= CAP_RESET;
        end else begin
            r_live    <= 1'b1;
            r_stopped <= n_stopped;
            r_valid   <= accept;
            r_popped  <= accept && n_popped;
            if (i_cfg_we && i_cfg_idx == CFG_HIGH_CAP) begin
                r_high_cap <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_LOW_CAP) begin
                r_low_cap <= i_cfg_data;
            end
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_lane   <= n_lane;
        end
    end

    tpq_lane #(
        .DEPTH      (HIGH_DEPTH),
        .WORD_BITS  (SW),
        .COUNT_BITS (COUNT_BITS)
    ) u_high (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (high_ctl),
        .i_word     (word),
        .i_cap      (r_high_cap),
        .o_stat     (high_stat),
        .o_count    (high_count),
        .o_rdata    (high_rdata),
        .o_rejected (high_rej),
        .o_enqueued (high_enq)
    );

    tpq_lane #(
        .DEPTH      (LOW_DEPTH),
        .WORD_BITS  (SW),
        .COUNT_BITS (COUNT_BITS)
    ) u_low (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (low_ctl),
        .i_word     (word),
        .i_cap      (r_low_cap),
        .o_stat     (low_stat),
        .o_count    (low_count),
        .o_rdata    (low_rdata),
        .o_rejected (low_rej),
        .o_enqueued (low_enq)
    );

    // result ports: sizes and totals already reflect the request just taken
    assign o_busy          = !r_live;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_popped_lane   = r_popped && r_lane;
    assign o_popped_task   = !r_popped ? '0 :
                             r_lane ? FIELD_W'(low_rdata) : FIELD_W'(high_rdata);
    assign o_high_size     = SIZE_W'(high_count);
    assign o_low_size      = SIZE_W'(low_count);
    assign o_high_rejected = FIELD_W'(high_rej);
    assign o_low_rejected  = FIELD_W'(low_rej);
    assign o_high_enqueued = FIELD_W'(high_enq);
    assign o_low_enqueued  = FIELD_W'(low_enq);

endmodule

// File: rtl/tpq_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module tpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tpq_lane.sv
`timescale 1ns / 1ps
// one bounded fifo lane: entry ram, head and fill, capacity check, totals
// depends on tpq_pkg and tpq_ram
module tpq_lane #(
    parameter int DEPTH      = 16,
    parameter int WORD_BITS  = 32,
    parameter int COUNT_BITS = 32,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tpq_pkg::t_lane_ctl        i_ctl,
    input  logic [WORD_BITS-1:0]      i_word,
    input  logic [tpq_pkg::CAP_W-1:0] i_cap,
    output tpq_pkg::t_lane_stat       o_stat,
    output logic [CW-1:0]             o_count,
    output logic [WORD_BITS-1:0]      o_rdata,
    output logic [COUNT_BITS-1:0]     o_rejected,
    output logic [COUNT_BITS-1:0]     o_enqueued
);
    import tpq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);

    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [COUNT_BITS-1:0] r_rej, n_rej;
    logic [COUNT_BITS-1:0] r_enq, n_enq;

    logic [KW-1:0] cap_min1;
    logic [KW-1:0] cap_eff;
    logic          full;
    logic          push_ok;
    logic [CW:0]   wsum;
    logic [AW-1:0] waddr;

    // effective capacity: zero acts as one, clamp to depth
    always_comb begin
        cap_min1 = (i_cap == '0) ? KW'(1) : KW'(i_cap);
        cap_eff  = (cap_min1 > DEPTH_K) ? DEPTH_K : cap_min1;
        full     = (KW'(r_count) >= cap_eff);
        push_ok  = i_ctl.push && !full;
    end

    // tail address, head plus fill wrapped once
    always_comb begin
        wsum  = (CW + 1)'(r_head) + (CW + 1)'(r_count);
        if (wsum >= DEPTH_S) begin
            wsum = wsum - DEPTH_S;
        end
        waddr = AW'(wsum);
    end

    // head, fill and saturating totals
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_rej   = r_rej;
        n_enq   = r_enq;
        if (push_ok) begin
            n_count = r_count + CW'(1);
            if (r_enq != '1) begin
                n_enq = r_enq + COUNT_BITS'(1);
            end
        end else if (i_ctl.push) begin
            if (r_rej != '1) begin
                n_rej = r_rej + COUNT_BITS'(1);
            end
        end else if (i_ctl.pop) begin
            n_count = r_count - CW'(1);
            n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rej   <= '0;
            r_enq   <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rej   <= n_rej;
            r_enq   <= n_enq;
        end
    end

    // entry store, read always at the head
    tpq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (waddr),
        .i_wdata (i_word),
        .i_raddr (r_head),
        .o_rdata (o_rdata)
    );

    assign o_stat.full  = full;
    assign o_stat.empty = (r_count == '0);
    assign o_count      = r_count;
    assign o_rejected   = r_rej;
    assign o_enqueued   = r_enq;

endmodule

// File: rtl/tpq_checker.sv
`timescale 1ns / 1ps
// port level checks for the two level priority task queue, bound to the top
// depends on tpq_pkg and two_level_priority_task_queue
module tpq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic [tpq_pkg::ACTION_W-1:0]  i_action,
    input logic                          o_valid,
    input logic [tpq_pkg::STATUS_W-1:0]  o_status,
    input logic [tpq_pkg::FIELD_W-1:0]   o_popped_task,
    input logic                          o_popped_lane,
    input logic [tpq_pkg::SIZE_W-1:0]    o_high_size
);
    import tpq_pkg::*;

    // one result strobe for each request taken, in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (o_valid == $past(i_start && !o_busy)))
        else $error("result strobe does not follow request");

    // status always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_ACCEPTED || o_status == ST_REJECTED ||
                     o_status == ST_POPPED || o_status == ST_EMPTY ||
                     o_status == ST_SHUTDOWN))
        else $error("undefined status code");

    // no task or lane shown unless a task was popped
    a_quiet_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_POPPED) |-> (o_popped_task == '0 && !o_popped_lane))
        else $error("payload on a result without a pop");

    // low lane served only with the high lane empty
    a_strict_priority: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_POPPED && o_popped_lane) |-> (o_high_size == '0))
        else $error("low lane served while high lane holds tasks");

    // shutdown is sticky for pops
    a_shutdown_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SHUTDOWN && i_start && !o_busy && i_action == ACT_POP)
        |=> (o_status == ST_SHUTDOWN))
        else $error("pop served after shutdown");

endmodule

bind two_level_priority_task_queue tpq_checker u_tpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .i_action      (i_action),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_popped_task (o_popped_task),
    .o_popped_lane (o_popped_lane),
    .o_high_size   (o_high_size)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for two_level_priority_task_queue: directed and random requests,
// each result checked against an in-bench model of the two lanes and their totals
// depends on tpq_pkg and the rtl of the block only
module tb_top;
    import tpq_pkg::*;

    localparam int HIGH_DEPTH = 16;
    localparam int LOW_DEPTH  = 16;
    localparam int TASK_BITS  = 32;
    localparam int COUNT_BITS = 32;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [FIELD_W-1:0]  word;
    } t_request;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  task_word;
        logic                lane;
        logic [SIZE_W-1:0]   high_size;
        logic [SIZE_W-1:0]   low_size;
        logic [FIELD_W-1:0]  high_rej;
        logic [FIELD_W-1:0]  low_rej;
        logic [FIELD_W-1:0]  high_enq;
        logic [FIELD_W-1:0]  low_enq;
    } t_reply;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [ACTION_W-1:0]  i_action;
    logic [FIELD_W-1:0]   i_task_word;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CAP_W-1:0]     i_cfg_data;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [FIELD_W-1:0]   o_popped_task;
    logic                 o_popped_lane;
    logic [SIZE_W-1:0]    o_high_size;
    logic [SIZE_W-1:0]    o_low_size;
    logic [FIELD_W-1:0]   o_high_rejected;
    logic [FIELD_W-1:0]   o_low_rejected;
    logic [FIELD_W-1:0]   o_high_enqueued;
    logic [FIELD_W-1:0]   o_low_enqueued;

    two_level_priority_task_queue #(
        .HIGH_DEPTH (HIGH_DEPTH),
        .LOW_DEPTH  (LOW_DEPTH),
        .TASK_BITS  (TASK_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_action        (i_action),
        .i_task_word     (i_task_word),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_popped_task   (o_popped_task),
        .o_popped_lane   (o_popped_lane),
        .o_high_size     (o_high_size),
        .o_low_size      (o_low_size),
        .o_high_rejected (o_high_rejected),
        .o_low_rejected  (o_low_rejected),
        .o_high_enqueued (o_high_enqueued),
        .o_low_enqueued  (o_low_enqueued)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // requests waiting to be driven and replies waiting to come back
    t_request             request_backlog[$];
    t_reply               replies_due[$];
    t_request             next_req;
    t_reply               due;
    logic                 last_taken = 1'b0;
    int                   idle_left  = 0;
    int                   gap_odds   = 0;

    // model of the lanes, registers and totals
    logic [FIELD_W-1:0]   high_lane[$];
    logic [FIELD_W-1:0]   low_lane[$];
    logic [CAP_W-1:0]     high_cap_reg = CAP_RESET;
    logic [CAP_W-1:0]     low_cap_reg  = CAP_RESET;
    logic [FIELD_W-1:0]   high_rej_total = '0;
    logic [FIELD_W-1:0]   low_rej_total  = '0;
    logic [FIELD_W-1:0]   high_enq_total = '0;
    logic [FIELD_W-1:0]   low_enq_total  = '0;
    logic                 stopped = 1'b0;

    // run statistics
    int                   error_count   = 0;
    int                   n_requests    = 0;
    int                   n_served      = 0;
    int                   n_full        = 0;
    int                   n_dry_pops    = 0;
    int                   n_shut_replies = 0;

    // register value 0 behaves as 1, anything past the depth as the depth
    function automatic int usable_depth(logic [CAP_W-1:0] raw, int depth);
        if (raw == '0)
            return 1;
        return (int'(raw) > depth) ? depth : int'(raw);
    endfunction

    // saturating total
    function automatic logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // apply one request to the model and return the reply it should give
    function automatic t_reply serve_request(logic [ACTION_W-1:0] act,
                                             logic [FIELD_W-1:0] word);
        t_reply r;
        r = '{default: '0};
        case (act)
            ACT_PUSH_HIGH: begin
                if (high_lane.size() < usable_depth(high_cap_reg, HIGH_DEPTH)) begin
                    high_lane.push_back(word);
                    high_enq_total = bump(high_enq_total);
                    r.status = ST_ACCEPTED;
                end else begin
                    high_rej_total = bump(high_rej_total);
                    r.status = ST_REJECTED;
                end
            end
            ACT_PUSH_LOW: begin
                if (low_lane.size() < usable_depth(low_cap_reg, LOW_DEPTH)) begin
                    low_lane.push_back(word);
                    low_enq_total = bump(low_enq_total);
                    r.status = ST_ACCEPTED;
                end else begin
                    low_rej_total = bump(low_rej_total);
                    r.status = ST_REJECTED;
                end
            end
            ACT_POP: begin
                if (stopped) begin
                    r.status = ST_SHUTDOWN;
                end else if (high_lane.size() != 0) begin
                    r.task_word = high_lane.pop_front();
                    r.status    = ST_POPPED;
                    r.lane      = 1'b0;
                end else if (low_lane.size() != 0) begin
                    r.task_word = low_lane.pop_front();
                    r.status    = ST_POPPED;
                    r.lane      = 1'b1;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            default: begin
                stopped  = 1'b1;
                r.status = ST_SHUTDOWN;
            end
        endcase
        r.high_size = SIZE_W'(high_lane.size());
        r.low_size  = SIZE_W'(low_lane.size());
        r.high_rej  = high_rej_total;
        r.low_rej   = low_rej_total;
        r.high_enq  = high_enq_total;
        r.low_enq   = low_enq_total;
        return r;
    endfunction

    // one line per mismatch, printing capped so a broken block cannot flood the log
    task automatic flag_mismatch(string msg);
        error_count++;
        if (error_count <= 40)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [FIELD_W-1:0] got,
                               logic [FIELD_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // monitor: check the reply in flight, then predict for a request taken at this edge
    always @(posedge i_clk) begin
        last_taken <= i_rst_n && i_start && !o_busy;
        if (i_rst_n) begin
            if (o_valid) begin
                if (replies_due.size() == 0) begin
                    flag_mismatch("result strobe with no request outstanding");
                end else begin
                    due = replies_due.pop_front();
                    check_field("status", FIELD_W'(o_status), FIELD_W'(due.status));
                    check_field("popped_task", o_popped_task, due.task_word);
                    check_field("popped_lane", FIELD_W'(o_popped_lane), FIELD_W'(due.lane));
                    check_field("high_size", FIELD_W'(o_high_size), FIELD_W'(due.high_size));
                    check_field("low_size", FIELD_W'(o_low_size), FIELD_W'(due.low_size));
                    check_field("high_rejected", o_high_rejected, due.high_rej);
                    check_field("low_rejected", o_low_rejected, due.low_rej);
                    check_field("high_enqueued", o_high_enqueued, due.high_enq);
                    check_field("low_enqueued", o_low_enqueued, due.low_enq);
                    case (due.status)
                        ST_POPPED:   n_served++;
                        ST_REJECTED: n_full++;
                        ST_EMPTY:    n_dry_pops++;
                        ST_SHUTDOWN: n_shut_replies++;
                        default: ;
                    endcase
                end
            end
            if (i_start && !o_busy) begin
                replies_due.push_back(serve_request(i_action, i_task_word));
                n_requests++;
            end
        end
    end

    // driver: hold a request until taken, insert idle bursts, then feed the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !last_taken) begin
            // request still waiting for the handshake
        end else if (idle_left > 0) begin
            i_start   <= 1'b0;
            idle_left = idle_left - 1;
        end else if (gap_odds != 0 && request_backlog.size() != 0 &&
                     $urandom_range(0, 99) < gap_odds) begin
            i_start   <= 1'b0;
            idle_left = $urandom_range(0, 12);
        end else if (request_backlog.size() != 0) begin
            next_req = request_backlog.pop_front();
            i_start     <= 1'b1;
            i_action    <= next_req.action;
            i_task_word <= next_req.word;
        end else begin
            i_start <= 1'b0;
        end
    end

    task automatic add_request(logic [ACTION_W-1:0] act, logic [FIELD_W-1:0] word);
        t_request r;
        r.action = act;
        r.word   = word;
        request_backlog.push_back(r);
    endtask

    // wait until every request is driven and every reply has come back
    task automatic settle();
        do begin
            @(negedge i_clk);
            #1;
        end while (request_backlog.size() != 0 || i_start || replies_due.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // write both capacity registers, block idle
    task automatic set_capacities(logic [CAP_W-1:0] hi, logic [CAP_W-1:0] lo);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HIGH_CAP;
        i_cfg_data <= hi;
        high_cap_reg = hi;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_LOW_CAP;
        i_cfg_data <= lo;
        low_cap_reg = lo;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [FIELD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // runs of mostly pushes or mostly pops so the lanes fill up and drain
    task automatic load_random_mix(int n_items, bit with_shutdown);
        int  made;
        int  run_len;
        int  push_pct;
        int  high_pct;
        int  k;
        logic [ACTION_W-1:0] act;
        made = 0;
        while (made < n_items) begin
            push_pct = $urandom_range(0, 1) ? 85 : 20;
            high_pct = $urandom_range(0, 2) * 40 + 10;
            run_len  = $urandom_range(1, 24);
            for (k = 0; k < run_len && made < n_items; k++) begin
                if (with_shutdown && made > n_items / 2 && $urandom_range(0, 29) == 0)
                    act = ACT_SHUTDOWN;
                else if ($urandom_range(0, 99) < push_pct)
                    act = ($urandom_range(0, 99) < high_pct) ? ACT_PUSH_HIGH : ACT_PUSH_LOW;
                else
                    act = ACT_POP;
                add_request(act, pick_word());
                made++;
            end
        end
    endtask

    // stimulus sequence
    initial begin
        logic [CAP_W-1:0] hi_caps[8];
        logic [CAP_W-1:0] lo_caps[8];
        int               gap_plan[8];
        int               p;

        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_action    = ACT_PUSH_HIGH;
        i_task_word = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_HIGH_CAP;
        i_cfg_data  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset capacities: pop on empty, priority order, word extremes
        add_request(ACT_POP, 32'h1234_5678);
        add_request(ACT_PUSH_HIGH, 32'h0000_0000);
        add_request(ACT_PUSH_HIGH, 32'hFFFF_FFFF);
        add_request(ACT_PUSH_LOW, 32'h0000_0000);
        add_request(ACT_PUSH_LOW, 32'hFFFF_FFFF);
        add_request(ACT_PUSH_HIGH, 32'hA5A5_5A5A);
        repeat (6) add_request(ACT_POP, 32'h0);
        settle();

        // zero capacity acts as one, oversize acts as the depth
        set_capacities(5'd0, 5'd31);
        add_request(ACT_PUSH_HIGH, 32'h0000_0001);
        add_request(ACT_PUSH_HIGH, 32'h0000_0002);
        add_request(ACT_PUSH_LOW, 32'h0000_0003);
        add_request(ACT_POP, 32'hFFFF_FFFF);
        add_request(ACT_POP, 32'h0);
        settle();

        // capacity lowered under the fill: entries kept, pushes refused until it drops
        set_capacities(5'd16, 5'd16);
        add_request(ACT_PUSH_HIGH, 32'h0000_0011);
        add_request(ACT_PUSH_HIGH, 32'h0000_0022);
        add_request(ACT_PUSH_HIGH, 32'h0000_0033);
        settle();
        set_capacities(5'd1, 5'd16);
        add_request(ACT_PUSH_HIGH, 32'h0000_0044);
        add_request(ACT_POP, 32'h0);
        add_request(ACT_POP, 32'h0);
        add_request(ACT_PUSH_HIGH, 32'h0000_0055);
        add_request(ACT_POP, 32'h0);
        add_request(ACT_PUSH_HIGH, 32'h0000_0066);
        add_request(ACT_POP, 32'h0);
        settle();

        // random phases over a spread of capacities, lanes carried across phases
        hi_caps  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd3, 5'd9, 5'd16};
        lo_caps  = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd12, 5'd2, 5'd16};
        gap_plan = '{25, 0, 40, 10, 60, 0, 30, 0};
        for (p = 0; p < 8; p++) begin
            if (p == 5 || p == 6) begin
                hi_caps[p] = CAP_W'($urandom_range(0, 31));
                lo_caps[p] = CAP_W'($urandom_range(0, 31));
            end
            set_capacities(hi_caps[p], lo_caps[p]);
            gap_odds = gap_plan[p];
            load_random_mix(104, p == 7);
            settle();
        end

        // shutdown: sticky, pops refused, pushes still taken
        add_request(ACT_SHUTDOWN, 32'hDEAD_BEEF);
        add_request(ACT_POP, 32'h0);
        add_request(ACT_PUSH_HIGH, 32'h0BAD_F00D);
        add_request(ACT_PUSH_LOW, 32'h7777_7777);
        add_request(ACT_POP, 32'h0);
        add_request(ACT_SHUTDOWN, 32'h0);
        settle();

        repeat (4) @(posedge i_clk);
        if (replies_due.size() != 0)
            flag_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
        $display("covered %0d requests: %0d pops served, %0d full refusals,",
                 n_requests, n_served, n_full);
        $display("%0d pops on empty lanes, %0d shutdown replies, eight capacity settings",
                 n_dry_pops, n_shut_replies);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("timeout: replies stopped arriving");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
rtl/tpq_pkg.sv
rtl/tpq_ram.sv
rtl/tpq_lane.sv
rtl/two_level_priority_task_queue.sv
rtl/tpq_checker.sv
tb/sv/tb_top.sv
